### src/dram_refresh_arbiter_unit_macros.svh
// ----------------------------------------------------------------------------
// dram refresh arbiter assertion macros
// shared property wrappers for the checker, clocked on i_clk
// ----------------------------------------------------------------------------
`ifndef DRAM_REFRESH_ARBITER_UNIT_MACROS_SVH
`define DRAM_REFRESH_ARBITER_UNIT_MACROS_SVH

// property checked only while out of reset
`define DRAU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property that also covers the reset cycles
`define DRAU_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### src/drau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drau_pkg
// types, constants and helpers shared by the refresh arbiter modules
// ----------------------------------------------------------------------------
package drau_pkg;

    // sizing
    localparam int MAX_RANKS    = 8;
    localparam int TIME_BITS    = 48;
    localparam int RANK_W       = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
    localparam int RANK_CNT_W   = $clog2(MAX_RANKS + 1);
    localparam int FIELD_TIME_W = 48;
    localparam int FIELD_RANK_W = 3;
    localparam int DELAY_W      = 8;
    localparam int AGE_W        = 20;
    localparam int INTERVAL_W   = 20;
    localparam int RANKS_CFG_W  = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 20;
    localparam int DIV_STEP_W   = $clog2(INTERVAL_W);

    // register reset values
    localparam int RST_REFRESH_ENABLE = 1;
    localparam int RST_BUFFER_DELAY   = 1;
    localparam int RST_AGE_LIMIT      = 1024;
    localparam int RST_INTERVAL       = 7800;
    localparam int RST_RANKS_IN_USE   = 2;
    localparam int RST_ACTIVE_RANKS   = (RST_RANKS_IN_USE < 1) ? 1 :
                                        (RST_RANKS_IN_USE > MAX_RANKS) ? MAX_RANKS :
                                        RST_RANKS_IN_USE;
    localparam int RST_STAGGER_STEP   = RST_INTERVAL / RST_ACTIVE_RANKS + 1;

    typedef logic [TIME_BITS-1:0]  t_time;
    typedef logic [RANK_W-1:0]     t_rank;
    typedef logic [RANK_CNT_W-1:0] t_rank_cnt;

    typedef enum logic [1:0] {
        REQ_PEEK       = 2'd0,
        REQ_PEEK_DELAY = 2'd1,
        REQ_TAKE       = 2'd2,
        REQ_RESTART    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        GRANT_NONE    = 2'd0,
        GRANT_HEAD    = 2'd1,
        GRANT_REFRESH = 2'd2
    } t_grant;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REFRESH_ENABLE = 3'd0,
        CFG_BUFFER_DELAY   = 3'd1,
        CFG_AGE_LIMIT      = 3'd2,
        CFG_INTERVAL       = 3'd3,
        CFG_RANKS_IN_USE   = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_STAG,
        ST_SCAN,
        ST_POST,
        ST_P_READY,
        ST_P_SENIOR,
        ST_P_FRESH,
        ST_P_WAITED,
        ST_REARM,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_req                    req_type;
        logic [FIELD_TIME_W-1:0] current_time;
        logic                    head_valid;
        logic [FIELD_TIME_W-1:0] head_enqueue_time;
    } t_in_item;

    typedef struct packed {
        t_grant                  grant;
        logic [FIELD_RANK_W-1:0] refresh_rank;
        logic [FIELD_TIME_W-1:0] refresh_due;
        logic [FIELD_TIME_W-1:0] next_refresh_due;
    } t_out_item;

    typedef struct packed {
        logic                   refresh_enable;
        logic [DELAY_W-1:0]     buffer_delay;
        logic [AGE_W-1:0]       seniority_age_limit;
        logic [INTERVAL_W-1:0]  refresh_interval;
        logic [RANKS_CFG_W-1:0] ranks_in_use;
    } t_cfg;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_alu_flags;

    // wrap a value onto the time width
    function automatic t_time to_time(input logic [63:0] v);
        return v[TIME_BITS-1:0];
    endfunction

    // time value as a payload field
    function automatic logic [FIELD_TIME_W-1:0] time_to_field(input t_time t);
        logic [63:0] w;
        w = 64'(t);
        return w[FIELD_TIME_W-1:0];
    endfunction

    // rank index as a payload field, low bits only
    function automatic logic [FIELD_RANK_W-1:0] rank_to_field(input t_rank r);
        logic [31:0] w;
        w = 32'(r);
        return w[FIELD_RANK_W-1:0];
    endfunction

    // ranks that take part, clamped to one through MAX_RANKS
    function automatic t_rank_cnt active_ranks(input logic [RANKS_CFG_W-1:0] r);
        if (r == '0) begin
            return t_rank_cnt'(1);
        end
        if (32'(r) > MAX_RANKS) begin
            return t_rank_cnt'(MAX_RANKS);
        end
        return t_rank_cnt'(r);
    endfunction

endpackage

### src/dram_refresh_arbiter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dram_refresh_arbiter_unit
// refresh / queue-head decode arbiter with per-rank refresh deadlines
// ----------------------------------------------------------------------------
// One item at a time; o_in_stall stays high while an item is in work. With n
// active ranks a peek, or a take that does not grant a refresh, goes through n
// scan steps, one wrap-up, four compare steps and a handoff to the result
// register; a take that grants a refresh adds a rearm, a second scan and its
// wrap-up. A restart runs the step divider (one quotient bit per cycle), writes
// all MAX_RANKS deadlines one per cycle and rescans. The scan, stagger, compare
// and rearm steps all go through the single shared time adder/comparator. The
// deadlines reset at once to the default stagger, so there is no clearing pass.
// The result register lets the next item be accepted while a result waits to be
// taken. Configuration writes are always ready and must only happen while the
// block is idle.
module dram_refresh_arbiter_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  drau_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output drau_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [drau_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [drau_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import drau_pkg::*;

    t_cfg      r_cfg;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      core_busy;
    logic      core_done;
    t_out_item core_result;
    logic      in_accept;
    logic      out_free;
    logic      out_load;

    assign in_accept   = i_in_valid && !core_busy;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign out_load    = core_done && out_free;
    assign o_in_stall  = core_busy;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.refresh_enable      <= 1'(RST_REFRESH_ENABLE);
            r_cfg.buffer_delay        <= DELAY_W'(RST_BUFFER_DELAY);
            r_cfg.seniority_age_limit <= AGE_W'(RST_AGE_LIMIT);
            r_cfg.refresh_interval    <= INTERVAL_W'(RST_INTERVAL);
            r_cfg.ranks_in_use        <= RANKS_CFG_W'(RST_RANKS_IN_USE);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_REFRESH_ENABLE: r_cfg.refresh_enable      <= i_cfg_data[0];
                CFG_BUFFER_DELAY:   r_cfg.buffer_delay        <= i_cfg_data[DELAY_W-1:0];
                CFG_AGE_LIMIT:      r_cfg.seniority_age_limit <= i_cfg_data[AGE_W-1:0];
                CFG_INTERVAL:       r_cfg.refresh_interval    <= i_cfg_data[INTERVAL_W-1:0];
                CFG_RANKS_IN_USE:   r_cfg.ranks_in_use        <= i_cfg_data[RANKS_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    drau_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_accept),
        .i_item     (i_in_item),
        .i_cfg      (r_cfg),
        .i_out_free (out_free),
        .o_busy     (core_busy),
        .o_done     (core_done),
        .o_result   (core_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item <= core_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### src/drau_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drau_alu
// shared time adder / subtractor with a magnitude compare on its sum
// ----------------------------------------------------------------------------
module drau_alu (
    input  drau_pkg::t_time      i_a,
    input  drau_pkg::t_time      i_b,
    input  drau_pkg::t_time      i_c,
    input  logic                 i_sub,
    output drau_pkg::t_time      o_sum,
    output drau_pkg::t_alu_flags o_flags
);
    import drau_pkg::*;

    // wrapping sum or difference
    assign o_sum = i_sub ? (i_a - i_b) : (i_a + i_b);

    // unsigned compare of the sum against the third operand
    assign o_flags.lt = (o_sum < i_c);
    assign o_flags.eq = (o_sum == i_c);

endmodule

### src/drau_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drau_divider
// restoring divider, one quotient bit per cycle, for the stagger step
// ----------------------------------------------------------------------------
module drau_divider (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [drau_pkg::INTERVAL_W-1:0]   i_dividend,
    input  drau_pkg::t_rank_cnt               i_divisor,
    output logic                              o_done,
    output logic [drau_pkg::INTERVAL_W-1:0]   o_quotient
);
    import drau_pkg::*;

    logic [INTERVAL_W-1:0] r_quo;
    logic [INTERVAL_W-1:0] n_quo;
    t_rank_cnt             r_rem;
    t_rank_cnt             n_rem;
    t_rank_cnt             r_den;
    logic [DIV_STEP_W-1:0] r_step;
    logic                  r_busy;
    logic                  r_done;
    logic [RANK_CNT_W:0]   rem_sh;
    logic [RANK_CNT_W:0]   diff;
    logic                  ge;

    // one shift-subtract step
    always_comb begin
        rem_sh = {r_rem, r_quo[INTERVAL_W-1]};
        diff   = rem_sh - {1'b0, r_den};
        ge     = (rem_sh >= {1'b0, r_den});
        n_rem  = ge ? diff[RANK_CNT_W-1:0] : rem_sh[RANK_CNT_W-1:0];
        n_quo  = {r_quo[INTERVAL_W-2:0], ge};
    end

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == DIV_STEP_W'(INTERVAL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend / quotient and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### src/drau_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drau_core
// sequencer around the shared alu: earliest-rank scan, grant decision,
// rearm and restart stagger over the per-rank due times
// ----------------------------------------------------------------------------
module drau_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  drau_pkg::t_in_item  i_item,
    input  drau_pkg::t_cfg      i_cfg,
    input  logic                i_out_free,
    output logic                o_busy,
    output logic                o_done,
    output drau_pkg::t_out_item o_result
);
    import drau_pkg::*;

    t_state     r_state, n_state;
    t_time      r_due [MAX_RANKS];
    t_rank_cnt  r_cnt, n_cnt;
    t_time      r_best_due, n_best_due;
    t_rank      r_best_rank, n_best_rank;
    t_rank      r_er, n_er;
    t_time      r_er_due, n_er_due;
    t_time      r_next, n_next;
    t_time      r_acc, n_acc;
    t_grant     r_grant, n_grant;
    logic       r_restart, n_restart;
    logic       r_second, n_second;
    logic       r_ready, n_ready;
    logic       r_senior, n_senior;
    logic       r_fresh, n_fresh;
    t_in_item   r_in;

    t_time      alu_a, alu_b, alu_c, alu_sum;
    logic       alu_sub;
    t_alu_flags alu_flags;

    logic       due_we;
    t_rank      due_wa;
    t_time      due_wd;

    logic                  div_start;
    logic                  div_done;
    logic [INTERVAL_W-1:0] div_quo;

    t_time      now, enq, delay;
    t_rank_cnt  n_act, last;
    t_rank      idx;
    logic       waited;
    t_grant     grant;

    // captured request and derived operands
    assign now   = to_time(64'(r_in.current_time));
    assign enq   = to_time(64'(r_in.head_enqueue_time));
    assign delay = (r_in.req_type == REQ_PEEK) ? '0 : to_time(64'(i_cfg.buffer_delay));
    assign n_act = active_ranks(i_cfg.ranks_in_use);
    assign last  = n_act - 1'b1;
    assign idx   = r_cnt[RANK_W-1:0];

    drau_alu u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_c     (alu_c),
        .i_sub   (alu_sub),
        .o_sum   (alu_sum),
        .o_flags (alu_flags)
    );

    drau_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_cfg.refresh_interval),
        .i_divisor  (n_act),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // grant decision from the compare flags, waited comes from this cycle
    always_comb begin
        waited = !alu_flags.lt;
        grant  = GRANT_NONE;
        if (!i_cfg.refresh_enable) begin
            if (r_in.head_valid && waited) begin
                grant = GRANT_HEAD;
            end
        end else if (r_in.head_valid && r_senior) begin
            if (r_fresh) begin
                grant = r_ready ? GRANT_REFRESH : GRANT_NONE;
            end else begin
                grant = GRANT_HEAD;
            end
        end else if (r_ready) begin
            grant = GRANT_REFRESH;
        end
    end

    // next state, alu operand select and due table writes
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_best_due  = r_best_due;
        n_best_rank = r_best_rank;
        n_er        = r_er;
        n_er_due    = r_er_due;
        n_next      = r_next;
        n_acc       = r_acc;
        n_grant     = r_grant;
        n_restart   = r_restart;
        n_second    = r_second;
        n_ready     = r_ready;
        n_senior    = r_senior;
        n_fresh     = r_fresh;
        alu_a       = '0;
        alu_b       = '0;
        alu_c       = '0;
        alu_sub     = 1'b0;
        due_we      = 1'b0;
        due_wa      = '0;
        due_wd      = '0;
        div_start   = 1'b0;
        o_done      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_cnt    = '0;
                    n_second = 1'b0;
                    if (i_item.req_type == REQ_RESTART) begin
                        n_restart = 1'b1;
                        div_start = 1'b1;
                        n_state   = ST_DIV;
                    end else begin
                        n_restart = 1'b0;
                        n_state   = ST_SCAN;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_state = ST_STAG;
                end
            end
            // entry j gets j * (step + 1), built as a running sum
            ST_STAG: begin
                alu_a  = r_acc;
                alu_b  = to_time(64'(div_quo) + 64'd1);
                due_we = 1'b1;
                due_wa = idx;
                due_wd = r_acc;
                n_acc  = alu_sum;
                if (r_cnt == t_rank_cnt'(MAX_RANKS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_SCAN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            // one rank per cycle, strict less-than keeps the lowest rank on a tie
            ST_SCAN: begin
                alu_a = r_due[idx];
                alu_c = r_best_due;
                if (r_cnt == '0 || alu_flags.lt) begin
                    n_best_due  = r_due[idx];
                    n_best_rank = idx;
                end
                if (r_cnt == last) begin
                    n_state = ST_POST;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_POST: begin
                if (r_restart) begin
                    n_er     = r_best_rank;
                    n_er_due = r_best_due;
                    n_next   = r_best_due;
                    n_grant  = GRANT_NONE;
                    n_state  = ST_DONE;
                end else if (r_second) begin
                    n_next  = r_best_due;
                    n_state = ST_DONE;
                end else begin
                    n_er     = r_best_rank;
                    n_er_due = r_best_due;
                    n_state  = ST_P_READY;
                end
            end
            // refresh ready: due + delay <= now
            ST_P_READY: begin
                alu_a   = r_er_due;
                alu_b   = delay;
                alu_c   = now;
                n_ready = alu_flags.lt || alu_flags.eq;
                n_state = ST_P_SENIOR;
            end
            // head not too old: enq < due + age limit
            ST_P_SENIOR: begin
                alu_a    = r_er_due;
                alu_b    = to_time(64'(i_cfg.seniority_age_limit));
                alu_c    = enq;
                n_senior = !alu_flags.lt && !alu_flags.eq;
                n_state  = ST_P_FRESH;
            end
            // head still in the buffer: now <= enq + delay
            ST_P_FRESH: begin
                alu_a   = enq;
                alu_b   = delay;
                alu_c   = now;
                n_fresh = !alu_flags.lt;
                n_state = ST_P_WAITED;
            end
            // head waited long enough: now - enq >= delay
            ST_P_WAITED: begin
                alu_a   = now;
                alu_b   = enq;
                alu_c   = delay;
                alu_sub = 1'b1;
                n_grant = grant;
                if (r_in.req_type == REQ_TAKE && grant == GRANT_REFRESH) begin
                    n_state = ST_REARM;
                end else begin
                    n_next  = r_er_due;
                    n_state = ST_DONE;
                end
            end
            // push the granted rank out by one interval, then rescan
            ST_REARM: begin
                alu_a    = r_er_due;
                alu_b    = to_time(64'(i_cfg.refresh_interval));
                due_we   = 1'b1;
                due_wa   = r_er;
                due_wd   = alu_sum;
                n_second = 1'b1;
                n_cnt    = '0;
                n_state  = ST_SCAN;
            end
            ST_DONE: begin
                o_done = 1'b1;
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_restart <= 1'b0;
            r_second  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_restart <= n_restart;
            r_second  <= n_second;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_best_due  <= n_best_due;
        r_best_rank <= n_best_rank;
        r_er        <= n_er;
        r_er_due    <= n_er_due;
        r_next      <= n_next;
        r_acc       <= n_acc;
        r_grant     <= n_grant;
        r_ready     <= n_ready;
        r_senior    <= n_senior;
        r_fresh     <= n_fresh;
        if (i_start && r_state == ST_IDLE) begin
            r_in <= i_item;
        end
    end

    // per-rank due times, reset to the default stagger
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_RANKS; j++) begin
                r_due[j] <= to_time(64'(j) * 64'(RST_STAGGER_STEP));
            end
        end else if (due_we) begin
            r_due[due_wa] <= due_wd;
        end
    end

    assign o_busy                    = (r_state != ST_IDLE);
    assign o_result.grant            = r_grant;
    assign o_result.refresh_rank     = rank_to_field(r_er);
    assign o_result.refresh_due      = time_to_field(r_er_due);
    assign o_result.next_refresh_due = time_to_field(r_next);

endmodule

### src/drau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drau_checker
// port-level checks on the refresh arbiter, bound to the top level
// ----------------------------------------------------------------------------
`include "dram_refresh_arbiter_unit_macros.svh"

module drau_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input drau_pkg::t_out_item o_out_item
);
    import drau_pkg::*;

    // reset empties the result register
    `DRAU_ASSERT_RST(a_out_empty_after_rst, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // an accepted item keeps the block busy on the next cycle
    `DRAU_ASSERT(a_busy_after_accept, i_in_valid && !o_in_stall |=> o_in_stall, "item accepted but block not busy")

    // a new result only shows up at the end of an item in work
    `DRAU_ASSERT(a_result_from_work, $rose(o_out_valid) |-> $past(o_in_stall), "result without an item in work")

    // a stalled result holds
    `DRAU_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item), "stalled result changed")

endmodule

bind dram_refresh_arbiter_unit drau_checker u_drau_checker (.*);

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives decode requests into the refresh arbiter, predicts every grant and
// refresh deadline in a local model of the rank schedule, and checks each
// result in order across several register settings with random back-pressure
// ----------------------------------------------------------------------------
module testbench;
    import drau_pkg::*;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 229;
    localparam int TAIL_CYCLES     = 64;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int HOLD_CYCLES     = 400;

    typedef struct {
        t_in_item  item;
        bit        known;
        t_out_item result;
    } t_dir_row;

    // clock, reset and block ports
    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // local copy of the schedule and the registers
    t_time     due_tab [MAX_RANKS];
    t_cfg      model_cfg;

    t_out_item grants_q [$];
    t_dir_row  dir_rows [$];
    t_cfg      phase_cfg [NUM_PHASES];
    int        mismatches = 0;
    int        cycles = 0;

    // receiver stall bursts and the long hold-off
    bit        rcv_idle_on = 1'b0;
    bit        snd_idle_on = 1'b0;
    int        burst_left = 0;
    int        hold_left = 0;
    bit        hold_go = 1'b0;
    bit        hold_used = 1'b0;

    assign out_stall = (burst_left != 0) || (hold_left != 0);

    dram_refresh_arbiter_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 20 ns clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // ranks taking part, clamped to one through MAX_RANKS
    function automatic int ranks_used();
        if (model_cfg.ranks_in_use == 0) begin
            return 1;
        end
        if (int'(model_cfg.ranks_in_use) > MAX_RANKS) begin
            return MAX_RANKS;
        end
        return int'(model_cfg.ranks_in_use);
    endfunction

    // spread the deadlines over all ranks
    function automatic void restagger();
        t_time step;
        step = t_time'(model_cfg.refresh_interval) / t_time'(ranks_used());
        for (int j = 0; j < MAX_RANKS; j++) begin
            due_tab[j] = t_time'(j) * (step + t_time'(1));
        end
    endfunction

    // lowest deadline among the active ranks, lowest index on a tie
    function automatic int earliest_rank();
        int best;
        best = 0;
        for (int j = 1; j < ranks_used(); j++) begin
            if (due_tab[j] < due_tab[best]) begin
                best = j;
            end
        end
        return best;
    endfunction

    // decode decision for one request, rearming the granted rank on a take
    function automatic t_out_item arbitrate(input t_in_item it);
        t_out_item r;
        t_time     now;
        t_time     enq;
        t_time     delay;
        t_time     due;
        t_time     due_ready;
        t_time     age_edge;
        t_time     head_ready;
        t_time     waited;
        t_grant    g;
        int        er;
        now   = it.current_time;
        enq   = it.head_enqueue_time;
        delay = (it.req_type == REQ_PEEK) ? t_time'(0) : t_time'(model_cfg.buffer_delay);
        g     = GRANT_NONE;
        if (it.req_type == REQ_RESTART) begin
            restagger();
            er = earliest_rank();
            r.grant            = GRANT_NONE;
            r.refresh_rank     = 3'(er);
            r.refresh_due      = due_tab[er];
            r.next_refresh_due = due_tab[er];
            return r;
        end
        er  = earliest_rank();
        due = due_tab[er];
        if (!model_cfg.refresh_enable) begin
            waited = now - enq;
            if (it.head_valid && waited >= delay) begin
                g = GRANT_HEAD;
            end
        end else begin
            due_ready  = due + delay;
            age_edge   = due + t_time'(model_cfg.seniority_age_limit);
            head_ready = enq + delay;
            if (it.head_valid && enq < age_edge) begin
                if (now <= head_ready) begin
                    g = (due_ready <= now) ? GRANT_REFRESH : GRANT_NONE;
                end else begin
                    g = GRANT_HEAD;
                end
            end else if (now >= due_ready) begin
                g = GRANT_REFRESH;
            end
        end
        if (it.req_type == REQ_TAKE && g == GRANT_REFRESH) begin
            due_tab[er] = due + t_time'(model_cfg.refresh_interval);
        end
        r.grant            = g;
        r.refresh_rank     = 3'(er);
        r.refresh_due      = due;
        r.next_refresh_due = due_tab[earliest_rank()];
        return r;
    endfunction

    function automatic void add_row(input t_req req, input t_time now, input logic hv,
                                    input t_time enq, input bit known, input t_grant g,
                                    input int rank, input t_time due, input t_time nxt);
        t_dir_row row;
        row.item.req_type                = req;
        row.item.current_time            = now;
        row.item.head_valid              = hv;
        row.item.head_enqueue_time       = enq;
        row.known                        = known;
        row.result.grant                 = g;
        row.result.refresh_rank          = 3'(rank);
        row.result.refresh_due           = due;
        row.result.next_refresh_due      = nxt;
        dir_rows.push_back(row);
    endfunction

    // requests mostly placed around the earliest deadline, some fully random
    function automatic t_in_item random_item();
        t_in_item it;
        t_time    due;
        int       roll;
        int       span;
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            it.req_type = REQ_RESTART;
        end else if (roll < 25) begin
            it.req_type = REQ_PEEK;
        end else if (roll < 45) begin
            it.req_type = REQ_PEEK_DELAY;
        end else begin
            it.req_type = REQ_TAKE;
        end
        it.head_valid = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 9) < 8) begin
            due = due_tab[earliest_rank()];
            case ($urandom_range(0, 2))
                0: span = 4;
                1: span = 300;
                default: span = 3000;
            endcase
            it.current_time = due + t_time'($urandom_range(0, 2 * span)) - t_time'(span);
            case ($urandom_range(0, 3))
                0: it.head_enqueue_time = it.current_time
                       - t_time'($urandom_range(0, int'(model_cfg.buffer_delay) + 2));
                1: it.head_enqueue_time = due + t_time'(model_cfg.seniority_age_limit)
                       + t_time'($urandom_range(0, 4)) - t_time'(2);
                2: it.head_enqueue_time = it.current_time - t_time'($urandom_range(0, span));
                default: it.head_enqueue_time = due - t_time'($urandom_range(0, span));
            endcase
        end else begin
            it.current_time      = t_time'({$urandom(), $urandom()});
            it.head_enqueue_time = t_time'({$urandom(), $urandom()});
        end
        return it;
    endfunction

    // offer one item and record its expected result once it is taken
    task automatic offer(input t_in_item it, input bit known, input t_out_item fixed);
        t_out_item want;
        int        gap;
        if (snd_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        want = arbitrate(it);
        if (known) begin
            want = fixed;
        end
        grants_q.push_back(want);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_REFRESH_ENABLE: model_cfg.refresh_enable      = val[0];
            CFG_BUFFER_DELAY:   model_cfg.buffer_delay        = val[DELAY_W-1:0];
            CFG_AGE_LIMIT:      model_cfg.seniority_age_limit = val[AGE_W-1:0];
            CFG_INTERVAL:       model_cfg.refresh_interval    = val[INTERVAL_W-1:0];
            CFG_RANKS_IN_USE:   model_cfg.ranks_in_use        = val[RANKS_CFG_W-1:0];
            default: ;
        endcase
    endtask

    // wait until every outstanding result has been taken
    task automatic drain();
        in_valid <= 1'b0;
        while (grants_q.size() != 0) @(posedge clk);
    endtask

    // result check and receiver stall bursts
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (grants_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: grant %0d rank %0d due %h next %h",
                             out_item.grant, out_item.refresh_rank,
                             out_item.refresh_due, out_item.next_refresh_due);
                end
            end else begin
                want = grants_q.pop_front();
                if (out_item.grant !== want.grant
                        || out_item.refresh_rank !== want.refresh_rank
                        || out_item.refresh_due !== want.refresh_due
                        || out_item.next_refresh_due !== want.next_refresh_due) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: grant %0d/%0d rank %0d/%0d due %h/%h next %h/%h",
                                 want.grant, out_item.grant,
                                 want.refresh_rank, out_item.refresh_rank,
                                 want.refresh_due, out_item.refresh_due,
                                 want.next_refresh_due, out_item.next_refresh_due);
                    end
                end
            end
        end
        if (!rst_n) begin
            burst_left <= 0;
        end else if (burst_left != 0) begin
            burst_left <= burst_left - 1;
        end else if (rcv_idle_on && $urandom_range(0, 9) == 0) begin
            burst_left <= $urandom_range(1, 14);
        end
    end

    // long receiver hold-off so the block fills up and stalls its input
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // stimulus
    initial begin
        bit snd_plan [NUM_PHASES];
        bit rcv_plan [NUM_PHASES];
        t_cfg c;

        snd_plan = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        rcv_plan = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

        // reset register values and the default stagger
        model_cfg.refresh_enable      = 1'(RST_REFRESH_ENABLE);
        model_cfg.buffer_delay        = DELAY_W'(RST_BUFFER_DELAY);
        model_cfg.seniority_age_limit = AGE_W'(RST_AGE_LIMIT);
        model_cfg.refresh_interval    = INTERVAL_W'(RST_INTERVAL);
        model_cfg.ranks_in_use        = RANKS_CFG_W'(RST_RANKS_IN_USE);
        restagger();

        // register settings per phase: enable, delay, age limit, interval, ranks
        phase_cfg[0] = model_cfg;
        phase_cfg[1] = '{1'b1, 8'd0, 20'd0, 20'd1, 4'd1};
        phase_cfg[2] = '{1'b0, 8'd255, 20'hFFFFF, 20'hFFFFF, 4'd8};
        phase_cfg[3] = '{1'b1, 8'd255, 20'hFFFFF, 20'd0, 4'd0};
        phase_cfg[4] = '{1'b1, 8'd7, 20'd300, 20'd5000, 4'd15};
        phase_cfg[5] = '{1'b0, 8'd0, 20'd10, 20'd3000, 4'd3};
        phase_cfg[6] = '{1'b1, 8'($urandom_range(0, 255)), 20'($urandom_range(0, 4095)),
                         20'($urandom_range(1, 20000)), 4'($urandom_range(1, 8))};
        phase_cfg[7] = '{1'b1, 8'd1, 20'd1024, 20'd7800, 4'd2};

        // directed rows, deadlines start at 0 and 3901 on two ranks
        add_row(REQ_PEEK,       48'd0, 1'b0, 48'd0, 1, GRANT_REFRESH, 0, 48'd0, 48'd0);
        add_row(REQ_PEEK_DELAY, 48'd0, 1'b0, 48'd0, 1, GRANT_NONE, 0, 48'd0, 48'd0);
        add_row(REQ_TAKE,       48'd1, 1'b0, 48'd0, 1, GRANT_REFRESH, 0, 48'd0, 48'd3901);
        add_row(REQ_PEEK, '1, 1'b1, '1, 1, GRANT_REFRESH, 1, 48'd3901, 48'd3901);
        add_row(REQ_TAKE, 48'd100, 1'b1, 48'd0, 1, GRANT_HEAD, 1, 48'd3901, 48'd3901);
        // head not yet past its delay, refresh just ready
        add_row(REQ_TAKE, 48'd3902, 1'b1, 48'd3901, 1, GRANT_REFRESH, 1, 48'd3901, 48'd7800);
        add_row(REQ_PEEK_DELAY, 48'd7000, 1'b1, 48'd6999, 1, GRANT_NONE, 0, 48'd7800,
                48'd7800);
        // head exactly at the seniority edge loses to the refresh
        add_row(REQ_TAKE, 48'd9000, 1'b1, 48'd8824, 1, GRANT_REFRESH, 0, 48'd7800,
                48'd11701);
        add_row(REQ_RESTART, 48'd0, 1'b0, 48'd0, 1, GRANT_NONE, 0, 48'd0, 48'd0);
        add_row(REQ_PEEK, 48'd0, 1'b1, '1, 1, GRANT_REFRESH, 0, 48'd0, 48'd0);
        // wrap-around and bit patterns, checked against the model
        add_row(REQ_TAKE, 48'd3, 1'b1, '1 - 48'd4, 0, GRANT_NONE, 0, '0, '0);
        add_row(REQ_PEEK_DELAY, '1, 1'b0, 48'd0, 0, GRANT_NONE, 0, '0, '0);
        add_row(REQ_TAKE, '1, 1'b1, '1, 0, GRANT_NONE, 0, '0, '0);
        add_row(REQ_TAKE, 48'd0, 1'b1, 48'd0, 0, GRANT_NONE, 0, '0, '0);
        add_row(REQ_PEEK, 48'h5555_5555_5555, 1'b1, 48'hAAAA_AAAA_AAAA, 0,
                GRANT_NONE, 0, '0, '0);
        add_row(REQ_TAKE, 48'hAAAA_AAAA_AAAA, 1'b1, 48'h5555_5555_5555, 0,
                GRANT_NONE, 0, '0, '0);
        add_row(REQ_RESTART, '1, 1'b1, '1, 0, GRANT_NONE, 0, '0, '0);
        add_row(REQ_TAKE, 48'd1, 1'b1, 48'd0, 0, GRANT_NONE, 0, '0, '0);
        add_row(REQ_PEEK_DELAY, 48'd3902, 1'b0, 48'd0, 0, GRANT_NONE, 0, '0, '0);
        add_row(REQ_TAKE, 48'd3902, 1'b0, 48'd0, 0, GRANT_NONE, 0, '0, '0);

        // reset
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        snd_idle_on = snd_plan[0];
        rcv_idle_on <= rcv_plan[0];
        foreach (dir_rows[i]) begin
            offer(dir_rows[i].item, dir_rows[i].known, dir_rows[i].result);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) begin
                drain();
                c = phase_cfg[p];
                write_reg(CFG_REFRESH_ENABLE, CFG_DATA_W'(c.refresh_enable));
                write_reg(CFG_BUFFER_DELAY, CFG_DATA_W'(c.buffer_delay));
                write_reg(CFG_AGE_LIMIT, CFG_DATA_W'(c.seniority_age_limit));
                write_reg(CFG_INTERVAL, CFG_DATA_W'(c.refresh_interval));
                write_reg(CFG_RANKS_IN_USE, CFG_DATA_W'(c.ranks_in_use));
                cfg_valid <= 1'b0;
                snd_idle_on = snd_plan[p];
                rcv_idle_on <= rcv_plan[p];
                // restart so the new interval and rank count take effect
                offer('{REQ_RESTART, 48'd0, 1'b0, 48'd0}, 1'b0, '0);
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (p == 1 && k == 40) begin
                    hold_go <= 1'b1;
                end
                offer(random_item(), 1'b0, '0);
            end
        end

        // let the last results come out, then allow for stragglers
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && grants_q.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
